[hw/rtl/ghb_pkg.sv]
// ----------------------------------------------------------------------------
// GHB stride prefetcher package
// Shared widths, constants and level tables for the prefetcher.
// ----------------------------------------------------------------------------
package ghb_pkg;

   localparam int IndexDepth     = 256;
   localparam int HistDepth      = 256;
   localparam int LineOffsetBits = 6;
   localparam int PageOffsetBits = 12;

   localparam int SlotW = $clog2(IndexDepth);
   localparam int HistW = $clog2(HistDepth);
   localparam int LineW = 64 - LineOffsetBits;

   localparam int ClearDepth = (IndexDepth > HistDepth) ? IndexDepth : HistDepth;
   localparam int ClearW     = $clog2(ClearDepth);

   localparam logic [2:0] LevelMin   = 3'd1;
   localparam logic [2:0] LevelMax   = 3'd5;
   localparam logic [2:0] LevelReset = 3'd3;
   localparam logic [6:0] CapReset   = 7'd32;

   localparam logic [0:0] RegMshrCapacity = 1'b0;

   typedef struct packed {
      logic [63:0] access_address;
      logic [7:0]  pc_low_bits;
      logic [6:0]  mshr_occupancy;
      logic        sample_point;
      logic [31:0] issued_count;
      logic [31:0] useful_count;
      logic [31:0] late_count;
   } req_type;

   typedef struct packed {
      logic [63:0] prefetch_address;
      logic        fill_to_l2;
      logic        last;
   } rsp_type;

   function automatic logic [1:0] lookahead_of(input logic [2:0] lvl);
      logic [1:0] r;
      begin
         r = (lvl >= 3'd4) ? 2'd2 : 2'd1;
         return r;
      end
   endfunction

   function automatic logic [5:0] degree_of(input logic [2:0] lvl);
      logic [5:0] r;
      begin
         case (lvl)
            3'd1: r = 6'd4;
            3'd2: r = 6'd6;
            3'd3: r = 6'd10;
            3'd4: r = 6'd16;
            3'd5: r = 6'd32;
            default: r = 6'd10;
         endcase
         return r;
      end
   endfunction

endpackage

[hw/rtl/ghb_req_if.sv]
// ----------------------------------------------------------------------------
// Request channel
// Valid/ready channel that carries one access word.
// ----------------------------------------------------------------------------
interface ghb_req_if;
   logic             valid;
   logic             ready;
   ghb_pkg::req_type data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

[hw/rtl/ghb_rsp_if.sv]
// ----------------------------------------------------------------------------
// Response channel
// Valid/ready channel that carries one prefetch word.
// ----------------------------------------------------------------------------
interface ghb_rsp_if;
   logic             valid;
   logic             ready;
   ghb_pkg::rsp_type data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

[hw/rtl/ghb_ram.sv]
// ----------------------------------------------------------------------------
// Generic RAM
// Single write port, single read port, registered read data.
// ----------------------------------------------------------------------------
module ghb_ram #(
   parameter int Width = 8,
   parameter int Depth = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(Depth)-1:0] wr_addr,
   input  logic [Width-1:0]         wr_data,
   input  logic [$clog2(Depth)-1:0] rd_addr,
   output logic [Width-1:0]         rd_data
);
   logic [Width-1:0] mem [Depth];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end
endmodule

[hw/rtl/ghb_stride_prefetcher_feedback.sv]
// ----------------------------------------------------------------------------
// GHB PC/CS stride prefetcher with feedback-directed aggressiveness
// Flow: an accepted request word passes the index read (S_IT) and the two
// dependent history reads (S_H1, S_H2); S_EMIT then registers its prefetch
// words. A new request word is taken only in S_IDLE, after the last word, when
// no prefetch falls in the page, or when the chain walk stops early.
// Reset: synchronous; a clearing pass invalidates the index table and the
// history links before the first request word is taken.
// ----------------------------------------------------------------------------
module ghb_stride_prefetcher_feedback (
   input  logic        clock,
   input  logic        reset,
   ghb_req_if.sink     req,
   ghb_rsp_if.source   rsp,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [0:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);
   typedef enum logic [2:0] {
      S_CLEAR, S_IDLE, S_IT, S_H1, S_H2, S_EMIT
   } state_type;

   localparam int HW  = ghb_pkg::HistW;
   localparam int SW  = ghb_pkg::SlotW;
   localparam int LW  = ghb_pkg::LineW;
   localparam int CW  = ghb_pkg::ClearW;
   localparam int PW  = ghb_pkg::PageOffsetBits - ghb_pkg::LineOffsetBits;
   localparam int IEW = 1 + HW;
   localparam int HEW = 1 + HW + LW;

   state_type             state_ff;
   ghb_pkg::req_type      req_ff;
   logic [6:0]            cap_ff;
   logic [2:0]            level_ff, level_in;
   logic [HW-1:0]         head_ff;
   logic [CW-1:0]         clr_ff;
   logic [HW-1:0]         i1_ff;
   logic                  fwd_ff;
   logic [LW-1:0]         a1_ff, cur_ff;
   logic [LW:0]           stride_ff;
   logic [5:0]            cnt_ff;
   logic                  fill_ff;
   logic                  rsp_valid_ff;
   ghb_pkg::rsp_type      rsp_data_ff;

   logic                  it_wr_en, hist_wr_en;
   logic [SW-1:0]         it_wr_addr, it_rd_addr;
   logic [IEW-1:0]        it_wr_data, it_rd_data;
   logic [HW-1:0]         hist_wr_addr, hist_rd_addr;
   logic [HEW-1:0]        hist_wr_data, hist_rd_data, hist_entry;
   logic [LW-1:0]         line, look_stride, nxt_line;
   logic [SW-1:0]         slot;
   logic [63:0]           pf_addr;
   logic                  in_page, nxt_in_page, last_word, load;
   logic [35:0]           u4, i3, u5, i2;
   logic [38:0]           l100;
   logic                  fb_high, fb_low, fb_late;

   assign line       = req_ff.access_address[63:ghb_pkg::LineOffsetBits];
   assign slot       = req_ff.pc_low_bits[SW-1:0];
   assign it_rd_addr = req.data.pc_low_bits[SW-1:0];
   assign hist_entry = fwd_ff ? {1'b1, i1_ff, line} : hist_rd_data;

   always_comb begin
      it_wr_en     = 1'b0;
      it_wr_addr   = slot;
      it_wr_data   = {1'b1, head_ff};
      hist_wr_en   = 1'b0;
      hist_wr_addr = head_ff;
      hist_wr_data = {it_rd_data, line};
      case (state_ff)
         S_CLEAR: begin
            it_wr_en     = int'(clr_ff) < ghb_pkg::IndexDepth;
            it_wr_addr   = SW'(clr_ff);
            it_wr_data   = '0;
            hist_wr_en   = int'(clr_ff) < ghb_pkg::HistDepth;
            hist_wr_addr = HW'(clr_ff);
            hist_wr_data = '0;
         end
         S_IT: begin
            it_wr_en   = 1'b1;
            hist_wr_en = 1'b1;
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      case (state_ff)
         S_IT:    hist_rd_addr = it_rd_data[HW-1:0];
         default: hist_rd_addr = hist_entry[HW+LW-1:LW];
      endcase
   end

   ghb_ram #(.Width(IEW), .Depth(ghb_pkg::IndexDepth)) u_index (
      .clock  (clock),
      .wr_en  (it_wr_en),
      .wr_addr(it_wr_addr),
      .wr_data(it_wr_data),
      .rd_addr(it_rd_addr),
      .rd_data(it_rd_data)
   );

   ghb_ram #(.Width(HEW), .Depth(ghb_pkg::HistDepth)) u_hist (
      .clock  (clock),
      .wr_en  (hist_wr_en),
      .wr_addr(hist_wr_addr),
      .wr_data(hist_wr_data),
      .rd_addr(hist_rd_addr),
      .rd_data(hist_rd_data)
   );

   assign u4   = {req_ff.useful_count, 2'b00} + 36'd0;
   assign i3   = {4'd0, req_ff.issued_count} + {3'd0, req_ff.issued_count, 1'b0};
   assign u5   = {4'd0, req_ff.useful_count} + {2'd0, req_ff.useful_count, 2'b00};
   assign i2   = {3'd0, req_ff.issued_count, 1'b0};
   assign l100 = {1'b0, req_ff.late_count, 6'd0} + {2'b0, req_ff.late_count, 5'd0}
               + {5'b0, req_ff.late_count, 2'd0};
   assign fb_high = u4 > i3;
   assign fb_low  = u5 < i2;
   assign fb_late = l100 > {7'd0, req_ff.useful_count};

   always_comb begin
      level_in = level_ff;
      if (req_ff.sample_point && req_ff.issued_count != 32'd0
          && req_ff.useful_count != 32'd0 && fb_late) begin
         if (fb_low) begin
            if (level_ff > ghb_pkg::LevelMin) level_in = level_ff - 3'd1;
         end else if (fb_high || !fb_low) begin
            if (level_ff < ghb_pkg::LevelMax) level_in = level_ff + 3'd1;
         end
      end
   end

   assign look_stride = (ghb_pkg::lookahead_of(level_ff) == 2'd2)
                      ? {stride_ff[LW-2:0], 1'b0} : stride_ff[LW-1:0];
   assign nxt_line    = cur_ff + stride_ff[LW-1:0];
   assign pf_addr     = {cur_ff, {ghb_pkg::LineOffsetBits{1'b0}}};
   assign in_page     = cur_ff[LW-1:PW]
                     == req_ff.access_address[63:ghb_pkg::PageOffsetBits];
   assign nxt_in_page = nxt_line[LW-1:PW]
                     == req_ff.access_address[63:ghb_pkg::PageOffsetBits];
   assign last_word   = (cnt_ff == 6'd0) || !nxt_in_page;
   assign load        = (state_ff == S_EMIT) && (!rsp_valid_ff || rsp.ready) && in_page;

   assign req.ready  = (state_ff == S_IDLE);
   assign rsp.valid  = rsp_valid_ff;
   assign rsp.data   = rsp_data_ff;
   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr == ghb_pkg::RegMshrCapacity) ? {25'd0, cap_ff} : 32'd0;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_ff       <= '0;
         cap_ff       <= ghb_pkg::CapReset;
         level_ff     <= ghb_pkg::LevelReset;
         head_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_psel && csr_penable && csr_pwrite
             && csr_paddr == ghb_pkg::RegMshrCapacity) begin
            cap_ff <= csr_pwdata[6:0];
         end
         if (load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp.ready) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            S_CLEAR: begin
               clr_ff <= clr_ff + 1'b1;
               if (clr_ff == CW'(ghb_pkg::ClearDepth - 1)) state_ff <= S_IDLE;
            end
            S_IDLE: begin
               if (req.valid) begin
                  req_ff   <= req.data;
                  state_ff <= S_IT;
               end
            end
            S_IT: begin
               level_ff <= level_in;
               head_ff  <= head_ff + 1'b1;
               i1_ff    <= it_rd_data[HW-1:0];
               fwd_ff   <= it_rd_data[HW-1:0] == head_ff;
               fill_ff  <= req_ff.mshr_occupancy < {1'b0, cap_ff[6:1]};
               state_ff <= it_rd_data[HW] ? S_H1 : S_IDLE;
            end
            S_H1: begin
               a1_ff     <= hist_entry[LW-1:0];
               stride_ff <= {1'b0, line} - {1'b0, hist_entry[LW-1:0]};
               state_ff  <= hist_entry[HEW-1] ? S_H2 : S_IDLE;
            end
            S_H2: begin
               cur_ff   <= line + look_stride;
               cnt_ff   <= ghb_pkg::degree_of(level_ff);
               state_ff <= (({1'b0, a1_ff} - {1'b0, hist_rd_data[LW-1:0]}) == stride_ff)
                         ? S_EMIT : S_IDLE;
            end
            S_EMIT: begin
               if (!rsp_valid_ff || rsp.ready) begin
                  if (in_page) begin
                     rsp_data_ff.prefetch_address <= pf_addr;
                     rsp_data_ff.fill_to_l2       <= fill_ff;
                     rsp_data_ff.last             <= last_word;
                     cur_ff <= nxt_line;
                     cnt_ff <= cnt_ff - 6'd1;
                     if (last_word) state_ff <= S_IDLE;
                  end else begin
                     state_ff <= S_IDLE;
                  end
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end
endmodule

[hw/rtl/ghb_checker.sv]
// ----------------------------------------------------------------------------
// GHB prefetcher port checker
// Watches the top-level ports for handshake and register port rules.
// ----------------------------------------------------------------------------
module ghb_checker (
   input logic             clock,
   input logic             reset,
   input logic             rsp_valid,
   input logic             rsp_ready,
   input ghb_pkg::rsp_type rsp_data,
   input logic             req_ready,
   input logic             csr_pready
);
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("response word dropped while stalled");
   a_pready: assert property (@(posedge clock) csr_pready)
      else $error("pready low");
   a_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.last |-> !req_ready)
      else $error("request taken during a burst");
endmodule

bind ghb_stride_prefetcher_feedback ghb_checker u_checker (
   .clock     (clock),
   .reset     (reset),
   .rsp_valid (rsp.valid),
   .rsp_ready (rsp.ready),
   .rsp_data  (rsp.data),
   .req_ready (req.ready),
   .csr_pready(csr_pready)
);

[test/testbench.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Stride prefetcher testbench
// Sends demand access words and checks every prefetch word against a local
// prediction of the history buffer, the PC chain walk and the feedback-driven
// aggressiveness level. The MSHR capacity register is changed between phases.
// ----------------------------------------------------------------------------
module testbench;

   class prefetch_scoreboard;
      ghb_pkg::rsp_type expected_words[$];
      int          errors;
      logic        slot_valid[ghb_pkg::IndexDepth];
      logic [7:0]  slot_entry[ghb_pkg::IndexDepth];
      logic [63:0] hist_line[ghb_pkg::HistDepth];
      logic        hist_link_valid[ghb_pkg::HistDepth];
      logic [7:0]  hist_link[ghb_pkg::HistDepth];
      logic [7:0]  head;
      logic [2:0]  level;
      logic [6:0]  capacity;

      function new();
         errors = 0;
         head = '0;
         level = ghb_pkg::LevelReset;
         capacity = ghb_pkg::CapReset;
         for (int i = 0; i < ghb_pkg::IndexDepth; i++) begin
            slot_valid[i] = 1'b0;
            slot_entry[i] = '0;
         end
         for (int i = 0; i < ghb_pkg::HistDepth; i++) begin
            hist_line[i] = '0;
            hist_link_valid[i] = 1'b0;
            hist_link[i] = '0;
         end
      endfunction

      function void adjust_level(ghb_pkg::req_type r);
         logic [63:0] iss, usf, lt;
         iss = {32'd0, r.issued_count};
         usf = {32'd0, r.useful_count};
         lt = {32'd0, r.late_count};
         if (!(r.sample_point && iss != 0 && usf != 0)) return;
         if (!(100 * lt > usf)) return;
         if (5 * usf < 2 * iss) begin
            if (level > ghb_pkg::LevelMin) level--;
         end else begin
            if (level < ghb_pkg::LevelMax) level++;
         end
      endfunction

      function void note_access(ghb_pkg::req_type r);
         logic [63:0] line, a0, a1, a2, s1, pf;
         logic [7:0]  h, i1, i2, slot;
         int          look, deg;
         ghb_pkg::rsp_type w;
         int          n;
         adjust_level(r);
         slot = r.pc_low_bits;
         line = r.access_address >> ghb_pkg::LineOffsetBits;
         h = head;
         hist_line[h] = line;
         hist_link_valid[h] = slot_valid[slot];
         hist_link[h] = slot_entry[slot];
         slot_valid[slot] = 1'b1;
         slot_entry[slot] = h;
         head = 8'(h + 1);
         a0 = hist_line[h];
         if (!hist_link_valid[h]) return;
         i1 = hist_link[h];
         a1 = hist_line[i1];
         if (!hist_link_valid[i1]) return;
         i2 = hist_link[i1];
         a2 = hist_line[i2];
         s1 = a0 - a1;
         if (s1 != a1 - a2) return;
         look = (level >= 4) ? 2 : 1;
         case (level)
            3'd1: deg = 4;
            3'd2: deg = 6;
            3'd4: deg = 16;
            3'd5: deg = 32;
            default: deg = 10;
         endcase
         n = 0;
         for (int k = look; k <= look + deg; k++) begin
            pf = (line + 64'(k) * s1) << ghb_pkg::LineOffsetBits;
            if ((pf >> ghb_pkg::PageOffsetBits)
                != (r.access_address >> ghb_pkg::PageOffsetBits)) break;
            w.prefetch_address = pf;
            w.fill_to_l2 = (r.mshr_occupancy < (capacity >> 1));
            w.last = 1'b0;
            expected_words.push_back(w);
            n++;
         end
         if (n > 0) expected_words[expected_words.size() - 1].last = 1'b1;
      endfunction

      function void check_word(ghb_pkg::rsp_type a);
         ghb_pkg::rsp_type e;
         if (expected_words.size() == 0) begin
            $display("%0t: unexpected prefetch word, actual %h", $time, a);
            errors++;
            return;
         end
         e = expected_words.pop_front();
         if (a.prefetch_address !== e.prefetch_address) begin
            $display("%0t: prefetch_address expected %h actual %h", $time,
                     e.prefetch_address, a.prefetch_address);
            errors++;
         end
         if (a.fill_to_l2 !== e.fill_to_l2) begin
            $display("%0t: fill_to_l2 expected %b actual %b", $time, e.fill_to_l2,
                     a.fill_to_l2);
            errors++;
         end
         if (a.last !== e.last) begin
            $display("%0t: last expected %b actual %b", $time, e.last, a.last);
            errors++;
         end
      endfunction
   endclass

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        csr_psel = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite = 1'b0;
   logic [0:0]  csr_paddr = ghb_pkg::RegMshrCapacity;
   logic [31:0] csr_pwdata = 32'd0;
   logic [31:0] csr_prdata;
   logic        csr_pready;
   logic        steady = 1'b0;
   int          quiet_cycles = 0;
   prefetch_scoreboard sb = new();

   ghb_req_if req ();
   ghb_rsp_if rsp ();

   initial begin
      req.valid = 1'b0;
      req.data = '0;
      rsp.ready = 1'b0;
   end

   ghb_stride_prefetcher_feedback i_dut (
      .clock(clock), .reset(reset), .req(req.sink), .rsp(rsp.source),
      .csr_psel(csr_psel), .csr_penable(csr_penable), .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr), .csr_pwdata(csr_pwdata), .csr_prdata(csr_prdata),
      .csr_pready(csr_pready)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   always @(posedge clock) begin
      if (!reset && rsp.valid && rsp.ready) sb.check_word(rsp.data);
      rsp.ready <= reset ? 1'b0 : (steady || $urandom_range(99) >= 37);
   end

   always @(posedge clock) begin
      if ((req.valid && req.ready) || (rsp.valid && rsp.ready) || csr_psel) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles > 3000) begin
         $display("testbench: errors");
         $finish;
      end
   end

   task automatic send_access(input ghb_pkg::req_type r);
      req.valid <= 1'b1;
      req.data <= r;
      do @(posedge clock); while (!req.ready);
      sb.note_access(r);
      if (!steady && $urandom_range(99) < 37) begin
         req.valid <= 1'b0;
         repeat ($urandom_range(3, 1)) @(posedge clock);
      end
   endtask

   task automatic access(input logic [63:0] addr, input logic [7:0] pc,
                         input logic [6:0] occ, input logic sp,
                         input logic [31:0] iss, input logic [31:0] usf,
                         input logic [31:0] lt);
      ghb_pkg::req_type r;
      r.access_address = addr;
      r.pc_low_bits = pc;
      r.mshr_occupancy = occ;
      r.sample_point = sp;
      r.issued_count = iss;
      r.useful_count = usf;
      r.late_count = lt;
      send_access(r);
   endtask

   task automatic set_capacity(input logic [6:0] value);
      @(posedge clock);
      req.valid <= 1'b0;
      while (sb.expected_words.size() != 0) @(posedge clock);
      repeat (50) @(posedge clock);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= ghb_pkg::RegMshrCapacity;
      csr_pwdata <= {25'd0, value};
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      sb.capacity = value;
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
   endtask

   logic [63:0] chain_addr[8];
   logic [63:0] chain_stride[8];

   task automatic random_access();
      ghb_pkg::req_type r;
      int      c;
      r.access_address = {$urandom, $urandom};
      r.pc_low_bits = 8'($urandom_range(255));
      r.mshr_occupancy = 7'($urandom_range(64));
      r.sample_point = ($urandom_range(99) < 25);
      r.issued_count = $urandom_range(1000, 1);
      case ($urandom_range(3))
         0: r.useful_count = r.issued_count;
         1: r.useful_count = r.issued_count / 2;
         2: r.useful_count = r.issued_count / 5;
         default: r.useful_count = $urandom;
      endcase
      r.late_count = ($urandom_range(1)) ? 32'd0 : $urandom_range(40);
      if ($urandom_range(9) == 0) begin
         r.issued_count = $urandom;
         r.late_count = $urandom;
      end
      if ($urandom_range(99) < 80) begin
         c = $urandom_range(7);
         if ($urandom_range(19) == 0) begin
            chain_addr[c] = {$urandom, $urandom};
            case ($urandom_range(3))
               0: chain_stride[c] = 64'd64;
               1: chain_stride[c] = -64'd64;
               2: chain_stride[c] = 64'($urandom_range(8, 1)) << 6;
               default: chain_stride[c] = {$urandom, $urandom};
            endcase
         end
         chain_addr[c] = chain_addr[c] + chain_stride[c];
         r.access_address = chain_addr[c] | 64'($urandom_range(63));
         r.pc_low_bits = 8'(c * 29 + 3);
      end
      send_access(r);
   endtask

   initial begin
      for (int c = 0; c < 8; c++) begin
         chain_addr[c] = 64'(c) << 20;
         chain_stride[c] = 64'($urandom_range(3, 1)) << 6;
      end
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      set_capacity(7'd64);
      access(64'h1000, 8'd1, 7'd0, 1'b0, 0, 0, 0);
      access(64'h1040, 8'd1, 7'd31, 1'b0, 0, 0, 0);
      access(64'h1080, 8'd1, 7'd32, 1'b0, 0, 0, 0);
      access(64'h2fc0, 8'd2, 7'd64, 1'b0, 0, 0, 0);
      access(64'h2f80, 8'd2, 7'd64, 1'b0, 0, 0, 0);
      access(64'h2f40, 8'd2, 7'd64, 1'b0, 0, 0, 0);
      access(64'h3000, 8'd3, 7'd5, 1'b0, 0, 0, 0);
      access(64'h3800, 8'd3, 7'd5, 1'b0, 0, 0, 0);
      access(64'h4000, 8'd3, 7'd5, 1'b0, 0, 0, 0);
      access(64'hffff_ffff_ffff_ff00, 8'd255, 7'd1, 1'b0, 0, 0, 0);
      access(64'hffff_ffff_ffff_ff40, 8'd255, 7'd1, 1'b0, 0, 0, 0);
      access(64'hffff_ffff_ffff_ff80, 8'd255, 7'd1, 1'b0, 0, 0, 0);
      access(64'h0, 8'd4, 7'd0, 1'b1, 32'd0, 32'd5, 32'd5);
      access(64'h40, 8'd4, 7'd0, 1'b1, 32'd100, 32'd100, 32'd50);
      access(64'h80, 8'd4, 7'd0, 1'b1, 32'd100, 32'd60, 32'd50);
      access(64'hc0, 8'd4, 7'd0, 1'b1, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff);
      access(64'h5000, 8'd5, 7'd0, 1'b0, 0, 0, 0);
      access(64'h5040, 8'd5, 7'd0, 1'b0, 0, 0, 0);
      access(64'h5080, 8'd5, 7'd0, 1'b1, 32'd100, 32'd100, 32'd0);
      for (int i = 0; i < 5; i++) begin
         access(64'h6000 + 64'(i) * 64, 8'd6, 7'd0, 1'b1, 32'd100, 32'd10, 32'd50);
      end
      access(64'h6140, 8'd6, 7'd0, 1'b1, 32'd10, 32'd9, 32'd20);
      set_capacity(7'd1);
      for (int i = 0; i < 80; i++) random_access();
      set_capacity(7'd20);
      steady = 1'b1;
      for (int i = 0; i < 55; i++) random_access();
      steady = 1'b0;
      set_capacity(7'd127);
      for (int i = 0; i < 60; i++) random_access();
      @(posedge clock);
      req.valid <= 1'b0;
      while (sb.expected_words.size() != 0) @(posedge clock);
      repeat (50) @(posedge clock);
      if (sb.errors == 0) begin
         $display("testbench: clean");
      end else begin
         $display("testbench: errors");
      end
      $finish;
   end

endmodule

[sim.f]
hw/rtl/ghb_pkg.sv
hw/rtl/ghb_req_if.sv
hw/rtl/ghb_rsp_if.sv
hw/rtl/ghb_ram.sv
hw/rtl/ghb_stride_prefetcher_feedback.sv
hw/rtl/ghb_checker.sv
test/testbench.sv
